### sv/pmid_pkg.sv
package pmid_pkg;

	// fixed field widths
	localparam int IDX_W  = 10;
	localparam int POS_W  = 32;
	localparam int BOX_W  = 30;
	localparam int AXES   = 3;
	localparam int CFG_W  = 2;

	// minimum-image arithmetic: signed working width, magnitude limit, square width
	localparam int SW     = 36;
	localparam int MAG_W  = 32;
	localparam int SQ_W   = 64;

	localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(65536);

	// configuration register indexes
	localparam logic [CFG_W-1:0] CFG_BOX_A = 2'd0;
	localparam logic [CFG_W-1:0] CFG_BOX_B = 2'd1;
	localparam logic [CFG_W-1:0] CFG_BOX_C = 2'd2;

	// command codes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef logic [AXES-1:0][BOX_W-1:0] box_set_t;

endpackage

### sv/pmid_store.sv
module pmid_store
	import pmid_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int W     = 96
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [W-1:0]  rdata_a,
	output logic [W-1:0]  rdata_b
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### sv/pmid_fold.sv
module pmid_fold
	import pmid_pkg::*;
#(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [COORD_BITS-1:0] x,
	input  logic [BOX_W-1:0]             box,
	output logic                         done,
	output logic [COORD_BITS-1:0]        res
);

	localparam int CNT_W = $clog2(COORD_BITS + 1);

	logic                  run_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;
	logic                  keep_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] mag_q;
	logic [BOX_W-1:0]      rem_q;
	logic [BOX_W:0]        trial;
	logic [BOX_W-1:0]      rem_d;
	logic [POS_W-1:0]      wide;

	// one restoring remainder step per cycle, magnitude bits msb first
	always_comb begin
		trial = {rem_q, mag_q[COORD_BITS-1]};
		if (trial >= {1'b0, box}) begin
			rem_d = BOX_W'(trial - {1'b0, box});
		end else begin
			rem_d = trial[BOX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(COORD_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			keep_q <= (x == '0) || (box == '0);
			neg_q  <= x[COORD_BITS-1];
			mag_q  <= x[COORD_BITS-1] ? COORD_BITS'(-x) : x;
			rem_q  <= '0;
		end else if (run_q) begin
			rem_q <= rem_d;
			mag_q <= mag_q << 1;
		end
	end

	// positive multiples land on box, negative multiples on zero
	always_comb begin
		wide = '0;
		if (neg_q) begin
			wide = (rem_q == '0) ? '0 : POS_W'(box) - POS_W'(rem_q);
		end else begin
			wide = (rem_q == '0) ? POS_W'(box) : POS_W'(rem_q);
		end
		res = keep_q ? x_q : wide[COORD_BITS-1:0];
	end

	assign done = done_q;

endmodule

### sv/pmid_dist.sv
module pmid_dist
	import pmid_pkg::*;
#(
	parameter int COORD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [AXES-1:0][COORD_BITS-1:0]  p,
	input  logic [AXES-1:0][COORD_BITS-1:0]  q,
	input  box_set_t                         box,
	output logic                             valid,
	output logic [SQ_W-1:0]                  dist_sq,
	output logic                             saturated
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	logic signed [SW-1:0] d_s1 [AXES];
	logic signed [SW-1:0] d_s2 [AXES];
	logic signed [SW-1:0] adj  [AXES];
	logic [SW-1:0]        mag  [AXES];
	logic [MAG_W-1:0]     mag_s3 [AXES];
	logic                 ovf_s3;
	logic                 ovf_d;
	logic [SQ_W-1:0]      sq_s4 [AXES];
	logic                 ovf_s4;
	logic [SQ_W:0]        sum_s5;
	logic [SQ_W-1:0]      sq2_s5;
	logic                 ovf_s5;
	logic [SQ_W+1:0]      total;
	logic [SQ_W-1:0]      dist_sq_s6;
	logic                 sat_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// raw difference
	always_ff @(posedge clk) begin
		for (int k = 0; k < AXES; k++) begin
			d_s1[k] <= SW'($signed(p[k])) - SW'($signed(q[k]));
		end
	end

	// minimum-image correction against half the box, compared as 2d vs box
	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			if ((d_s1[k] <<< 1) > $signed({{(SW-BOX_W){1'b0}}, box[k]})) begin
				adj[k] = d_s1[k] - $signed({{(SW-BOX_W){1'b0}}, box[k]});
			end else if ((d_s1[k] <<< 1) < -$signed({{(SW-BOX_W){1'b0}}, box[k]})) begin
				adj[k] = d_s1[k] + $signed({{(SW-BOX_W){1'b0}}, box[k]});
			end else begin
				adj[k] = d_s1[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < AXES; k++) begin
			d_s2[k] <= adj[k];
		end
	end

	always_comb begin
		ovf_d = 1'b0;
		for (int k = 0; k < AXES; k++) begin
			mag[k] = d_s2[k][SW-1] ? SW'(-d_s2[k]) : SW'(d_s2[k]);
			ovf_d  = ovf_d | (mag[k][SW-1:MAG_W] != '0);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < AXES; k++) begin
			mag_s3[k] <= mag[k][MAG_W-1:0];
			sq_s4[k]  <= mag_s3[k] * mag_s3[k];
		end
		ovf_s3 <= ovf_d;
		ovf_s4 <= ovf_s3;
		sum_s5 <= {1'b0, sq_s4[0]} + {1'b0, sq_s4[1]};
		sq2_s5 <= sq_s4[2];
		ovf_s5 <= ovf_s4;
	end

	assign total = {1'b0, sum_s5} + {2'b00, sq2_s5};

	always_ff @(posedge clk) begin
		sat_s6     <= ovf_s5 || (total[SQ_W+1:SQ_W] != '0);
		dist_sq_s6 <= (ovf_s5 || (total[SQ_W+1:SQ_W] != '0)) ? '1 : total[SQ_W-1:0];
	end

	assign valid     = valid_s6;
	assign dist_sq   = dist_sq_s6;
	assign saturated = sat_s6;

endmodule

### sv/periodic_min_image_distance.sv
// channel   direction  signals                                   transaction
// command   in         start, busy, mode, first_index,           start && !busy
//                      second_index, pos_x/y/z, wrap_first
// result    out        result_valid, dist_sq, saturated         result_valid (one cycle)
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// a load holds busy in S_EXEC; a query without wrap in S_EXEC and S_DATA; with wrap
// also in S_FOLD (the bit-serial remainder in the fold lanes), S_WB_I and S_WB_J.
// the squaring pipeline, started in the last busy state, raises the result strobe.
// reset clears the control state and sets all box lengths to 1.0; the position
// memory is not cleared. the receiver cannot stall results, none is ever held back.
module periodic_min_image_distance
	import pmid_pkg::*;
#(
	parameter int ATOM_SLOTS = 1024,
	parameter int COORD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    mode,
	input  logic [IDX_W-1:0]        first_index,
	input  logic [IDX_W-1:0]        second_index,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic                    wrap_first,
	output logic                    result_valid,
	output logic [SQ_W-1:0]         dist_sq,
	output logic                    saturated,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_W-1:0]        cfg_index,
	input  logic [BOX_W-1:0]        cfg_data
);

	localparam int AW    = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;
	localparam int RED_W = IDX_W + AW + 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_DATA = 6'b000100,
		S_FOLD = 6'b001000,
		S_WB_I = 6'b010000,
		S_WB_J = 6'b100000
	} state_t;

	state_t state_q;

	box_set_t box_q;

	logic                            mode_q;
	logic                            wrap_q;
	logic [AW-1:0]                   idx_i_q;
	logic [AW-1:0]                   idx_j_q;
	logic [AXES-1:0][COORD_BITS-1:0] pos_q;

	logic                            accept;
	logic                            we;
	logic                            re;
	logic [AW-1:0]                   waddr;
	logic [AXES-1:0][COORD_BITS-1:0] wdata;
	logic [AXES-1:0][COORD_BITS-1:0] rd_a;
	logic [AXES-1:0][COORD_BITS-1:0] rd_b;
	logic [1:0][AXES-1:0][COORD_BITS-1:0] fold_res;
	logic [1:0][AXES-1:0]            fold_done;
	logic                            fold_start;
	logic                            dist_start;
	logic [AXES-1:0][COORD_BITS-1:0] dist_p;
	logic [AXES-1:0][COORD_BITS-1:0] dist_q;

	// index modulo slot count by compare and subtract of shifted slot counts
	function automatic logic [AW-1:0] reduce_idx(input logic [IDX_W-1:0] v);
		logic [RED_W-1:0] r;
		r = RED_W'(v);
		for (int k = IDX_W - 1; k >= 0; k--) begin
			if (r >= (RED_W'(ATOM_SLOTS) << k)) begin
				r = r - (RED_W'(ATOM_SLOTS) << k);
			end
		end
		return r[AW-1:0];
	endfunction

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= {AXES{BOX_RESET}};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BOX_A: box_q[0] <= cfg_data;
				CFG_BOX_B: box_q[1] <= cfg_data;
				CFG_BOX_C: box_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode;
			wrap_q   <= wrap_first;
			idx_i_q  <= reduce_idx(first_index);
			idx_j_q  <= reduce_idx(second_index);
			pos_q[0] <= pos_x[COORD_BITS-1:0];
			pos_q[1] <= pos_y[COORD_BITS-1:0];
			pos_q[2] <= pos_z[COORD_BITS-1:0];
		end
	end

	// busy interlocks every read behind the previous write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: state_q <= (mode_q == MODE_QUERY) ? S_DATA : S_IDLE;
				S_DATA: state_q <= wrap_q ? S_FOLD : S_IDLE;
				S_FOLD: if (fold_done[0][0]) state_q <= S_WB_I;
				S_WB_I: state_q <= S_WB_J;
				S_WB_J: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign re    = (state_q == S_EXEC) && (mode_q == MODE_QUERY);
	assign we    = ((state_q == S_EXEC) && (mode_q == MODE_LOAD)) ||
	               (state_q == S_WB_I) || (state_q == S_WB_J);
	assign waddr = (state_q == S_WB_J) ? idx_j_q : idx_i_q;

	always_comb begin
		case (state_q)
			S_WB_I:  wdata = fold_res[0];
			S_WB_J:  wdata = fold_res[1];
			default: wdata = pos_q;
		endcase
	end

	pmid_store #(
		.DEPTH (ATOM_SLOTS),
		.AW    (AW),
		.W     (AXES * COORD_BITS)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (re),
		.raddr_a (idx_i_q),
		.raddr_b (idx_j_q),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign fold_start = (state_q == S_DATA) && wrap_q;

	for (genvar a = 0; a < 2; a++) begin : g_atom
		for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
			pmid_fold #(
				.COORD_BITS (COORD_BITS)
			) u_fold (
				.clk    (clk),
				.arst_n (arst_n),
				.start  (fold_start),
				.x      ((a == 0) ? rd_a[ax] : rd_b[ax]),
				.box    (box_q[ax]),
				.done   (fold_done[a][ax]),
				.res    (fold_res[a][ax])
			);
		end
	end

	assign dist_start = ((state_q == S_DATA) && !wrap_q) || (state_q == S_WB_J);
	assign dist_p     = (state_q == S_WB_J) ? fold_res[0] : rd_a;
	assign dist_q     = (state_q == S_WB_J) ? fold_res[1] : rd_b;

	pmid_dist #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (dist_start),
		.p         (dist_p),
		.q         (dist_q),
		.box       (box_q),
		.valid     (result_valid),
		.dist_sq   (dist_sq),
		.saturated (saturated)
	);

endmodule

### test/periodic_min_image_distance_test.sv
module periodic_min_image_distance_test;
	import pmid_pkg::*;

	localparam int ATOMS        = 1024;
	localparam int DRAIN_CYCLES = 60;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int PHASE_ITEMS  = 135;
	localparam logic [BOX_W-1:0] BOX_MAX = {BOX_W{1'b1}};
	localparam logic [CFG_W-1:0] BOX_REG [AXES] = '{CFG_BOX_A, CFG_BOX_B, CFG_BOX_C};

	typedef struct {
		logic [SQ_W-1:0] sum_sq;
		logic            sat;
	} dist_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic                    mode = MODE_LOAD;
	logic [IDX_W-1:0]        first_index = '0;
	logic [IDX_W-1:0]        second_index = '0;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic signed [POS_W-1:0] pos_z = '0;
	logic                    wrap_first = 1'b0;
	logic                    result_valid;
	logic [SQ_W-1:0]         dist_sq;
	logic                    saturated;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_W-1:0]        cfg_index = CFG_BOX_A;
	logic [BOX_W-1:0]        cfg_data = BOX_RESET;

	// shadow copy of the position table and box registers
	logic [POS_W-1:0] atom_pos [ATOMS][AXES];
	logic [BOX_W-1:0] box_len [AXES] = '{BOX_RESET, BOX_RESET, BOX_RESET};
	bit               written [ATOMS];
	int               written_list [$];

	dist_result_t pending_dist [$];
	dist_result_t want;

	int  errors = 0;
	int  cycle_count = 0;
	int  n_loads = 0;
	int  n_queries = 0;
	int  n_wrapped = 0;
	int  n_saturated = 0;
	int  n_box_settings = 1;
	bit  no_idle = 1'b0;

	periodic_min_image_distance i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.first_index  (first_index),
		.second_index (second_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.wrap_first   (wrap_first),
		.result_valid (result_valid),
		.dist_sq      (dist_sq),
		.saturated    (saturated),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_dist.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result checker: every strobe is one transaction
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_dist.size() == 0) begin
				$error("unexpected result: dist_sq=%h saturated=%b", dist_sq, saturated);
				errors++;
			end else begin
				want = pending_dist.pop_front();
				if (dist_sq !== want.sum_sq) begin
					$error("dist_sq: expected %h, got %h", want.sum_sq, dist_sq);
					errors++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %b, got %b", want.sat, saturated);
					errors++;
				end
			end
		end
	end

	// fold into [0, box]; a positive exact multiple lands on box, a negative one on 0
	function automatic longint fold_coord(longint c, longint bx);
		longint r;
		if (bx == 0 || c == 0)
			return c;
		if (c > 0) begin
			r = c % bx;
			return (r == 0) ? bx : r;
		end
		r = (-c) % bx;
		return (r == 0) ? 0 : bx - r;
	endfunction

	task automatic fold_atom(int a);
		for (int ax = 0; ax < AXES; ax++)
			atom_pos[a][ax] = POS_W'(fold_coord(longint'($signed(atom_pos[a][ax])),
				longint'(box_len[ax])));
	endtask

	task automatic predict_min_image(int a, int b, bit wrap);
		longint          d;
		longint          bx;
		longint unsigned mag;
		logic [65:0]     acc;
		bit              ovf;
		dist_result_t    res;
		acc = '0;
		ovf = 1'b0;
		if (wrap) begin
			fold_atom(a);
			fold_atom(b);
			n_wrapped++;
		end
		for (int ax = 0; ax < AXES; ax++) begin
			bx = longint'(box_len[ax]);
			d = longint'($signed(atom_pos[a][ax])) - longint'($signed(atom_pos[b][ax]));
			if (2 * d > bx)
				d -= bx;
			if (2 * d < -bx)
				d += bx;
			mag = (d < 0) ? longint'(-d) : d;
			if (mag >= (64'd1 << 32))
				ovf = 1'b1;
			else
				acc += {2'b00, mag * mag};
		end
		if (acc > {2'b00, {SQ_W{1'b1}}})
			ovf = 1'b1;
		res.sum_sq = ovf ? {SQ_W{1'b1}} : acc[SQ_W-1:0];
		res.sat    = ovf;
		if (ovf)
			n_saturated++;
		pending_dist.insert(pending_dist.size(), res);
	endtask

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_cmd(logic m, int a, int b, logic [POS_W-1:0] px,
			logic [POS_W-1:0] py, logic [POS_W-1:0] pz, logic w);
		int g;
		g = idle_gap();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
		start        <= 1'b1;
		mode         <= m;
		first_index  <= IDX_W'(a);
		second_index <= IDX_W'(b);
		pos_x        <= px;
		pos_y        <= py;
		pos_z        <= pz;
		wrap_first   <= w;
		do @(posedge clk); while (busy);
		// transaction taken at this edge
		if (m == MODE_LOAD) begin
			atom_pos[a][0] = px;
			atom_pos[a][1] = py;
			atom_pos[a][2] = pz;
			if (!written[a]) begin
				written[a] = 1'b1;
				written_list.insert(written_list.size(), a);
			end
			n_loads++;
		end else begin
			predict_min_image(a, b, w);
			n_queries++;
		end
	endtask

	task automatic load_atom(int a, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
			logic [POS_W-1:0] pz);
		send_cmd(MODE_LOAD, a, $urandom_range(0, ATOMS - 1), px, py, pz,
			1'($urandom_range(0, 1)));
	endtask

	task automatic query_atoms(int a, int b, logic w);
		send_cmd(MODE_QUERY, a, b, $urandom(), $urandom(), $urandom(), w);
	endtask

	// let the block go quiet: all results back, then a load or fold still finishing
	task automatic drain();
		start <= 1'b0;
		while (pending_dist.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_boxes(logic [BOX_W-1:0] a, logic [BOX_W-1:0] b,
			logic [BOX_W-1:0] c);
		logic [BOX_W-1:0] vals [AXES];
		vals = '{a, b, c};
		for (int ax = 0; ax < AXES; ax++) begin
			cfg_valid <= 1'b1;
			cfg_index <= BOX_REG[ax];
			cfg_data  <= vals[ax];
			do @(posedge clk); while (!cfg_ready);
			box_len[ax] = vals[ax];
		end
		cfg_valid <= 1'b0;
		n_box_settings++;
	endtask

	function automatic logic [POS_W-1:0] rand_coord(logic [BOX_W-1:0] bx);
		longint          span;
		longint          k;
		longint unsigned u;
		u = {$urandom(), $urandom()};
		span = 3 * longint'(bx);
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFFFFFF;
					1: return 32'h80000000;
					2: return 32'h00000000;
					default: return 32'hFFFFFFFF;
				endcase
			end
			1, 2: return $urandom();
			3: begin
				k = longint'($urandom_range(0, 8)) - 4;
				return POS_W'(k * longint'(bx));
			end
			default: return POS_W'(longint'(u % longint'(2 * span + 1)) - span);
		endcase
	endfunction

	function automatic int pick_atom();
		return written_list[$urandom_range(0, written_list.size() - 1)];
	endfunction

	task automatic test_extreme_positions();
		load_atom(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		load_atom(1, 32'h80000000, 32'h80000000, 32'h80000000);
		load_atom(ATOMS - 1, 32'h0, 32'h0, 32'h0);
		query_atoms(0, 1, 1'b0);
		query_atoms(ATOMS - 1, ATOMS - 1, 1'b0);
		query_atoms(0, ATOMS - 1, 1'b0);
	endtask

	task automatic test_half_box_boundary();
		// exactly half a box stays, one lsb over is corrected
		load_atom(5, 32'h00008000, 32'hFFFF8000, 32'h00008001);
		load_atom(6, 32'h0, 32'h0, 32'h0);
		query_atoms(5, 6, 1'b0);
		query_atoms(6, 5, 1'b0);
	endtask

	task automatic test_folding();
		load_atom(2, 32'h00030000, 32'hFFFE0000, 32'h0);
		load_atom(3, 32'h000103E8, 32'hFFFFFC18, 32'h00000005);
		query_atoms(2, 3, 1'b1);
		// folded positions must have been written back
		query_atoms(2, 3, 1'b0);
		query_atoms(0, 1, 1'b1);
		query_atoms(3, 3, 1'b1);
		query_atoms(0, 1, 1'b0);
	endtask

	task automatic test_box_extremes();
		drain();
		write_boxes(BOX_MAX, 30'd1, BOX_W'($urandom_range(1, BOX_MAX)));
		query_atoms(0, 1, 1'b0);
		query_atoms(0, 2, 1'b1);
		load_atom(4, $urandom(), $urandom(), $urandom());
		query_atoms(4, 1, 1'b1);
	endtask

	task automatic test_random_phase(logic [BOX_W-1:0] a, logic [BOX_W-1:0] b,
			logic [BOX_W-1:0] c);
		int ia;
		int ib;
		drain();
		write_boxes(a, b, c);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i % 45 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 35) begin
				send_cmd(MODE_LOAD, $urandom_range(0, ATOMS - 1), $urandom_range(0, ATOMS - 1),
					rand_coord(a), rand_coord(b), rand_coord(c), 1'($urandom_range(0, 1)));
			end else begin
				ia = pick_atom();
				ib = ($urandom_range(0, 9) == 0) ? ia : pick_atom();
				send_cmd(MODE_QUERY, ia, ib, $urandom(), $urandom(), $urandom(),
					1'($urandom_range(0, 1)));
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extreme_positions();
		test_half_box_boundary();
		test_folding();
		test_box_extremes();
		test_random_phase(BOX_RESET, BOX_RESET, BOX_RESET);
		test_random_phase(BOX_MAX, BOX_MAX, BOX_MAX);
		test_random_phase(30'd1, 30'd1, 30'd1);
		test_random_phase(BOX_W'($urandom_range(1, BOX_MAX)), BOX_W'($urandom_range(1, BOX_MAX)),
			BOX_W'($urandom_range(1, BOX_MAX)));
		test_random_phase(BOX_W'($urandom_range(1, 1 << 20)),
			BOX_W'($urandom_range(1, 1 << 20)), BOX_W'($urandom_range(1, 1 << 20)));
		test_random_phase(30'd1, BOX_MAX, BOX_W'($urandom_range(1, 1 << 20)));
		drain();
		$display("ran %0d loads and %0d queries, %0d of them folding, %0d saturated",
			n_loads, n_queries, n_wrapped, n_saturated);
		$display("used %0d box settings including both range limits", n_box_settings);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
